// ===== rtl/unit_name_path_escaper_unit_defines.svh =====
`ifndef UNIT_NAME_PATH_ESCAPER_UNIT_DEFINES_SVH
`define UNIT_NAME_PATH_ESCAPER_UNIT_DEFINES_SVH

// same-cycle implication on clk, quiet during rst
`define UPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, quiet during rst
`define UPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/upe_pkg.sv =====
package upe_pkg;

  localparam int MaxResults = 5;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int IdxW       = $clog2(MaxResults);

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [3:0] HexTen  = 4'd10;

  localparam logic [1:0] PhaseNone    = 2'd0;
  localparam logic [1:0] PhaseSkipped = 2'd1;
  localparam logic [1:0] PhaseKept    = 2'd2;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_name;
  } out_t;

  typedef struct packed {
    logic       pend;
    logic [1:0] phase;
  } st_t;

  typedef struct packed {
    out_t [MaxResults-1:0] item;
    logic [CntW-1:0]       count;
  } enc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < HexTen) begin
      return ChZero + {4'd0, nib};
    end
    return ChLowA + {4'd0, nib - HexTen};
  endfunction

  function automatic logic is_safe(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == ChColon || b == ChUnder || b == ChDot;
  endfunction

endpackage

// ===== rtl/upe_encode.sv =====
module upe_encode (
  input  upe_pkg::in_t  data,
  input  upe_pkg::st_t  st,
  output upe_pkg::enc_t enc,
  output upe_pkg::st_t  st_next
);

  logic [upe_pkg::CntW-1:0] n;
  logic                     first;
  logic                     esc;

  always_comb begin
    enc     = '0;
    st_next = st;
    n       = '0;
    first   = (st.phase == upe_pkg::PhaseNone) || (st.phase == upe_pkg::PhaseSkipped);
    esc     = (first && data.path_byte == upe_pkg::ChDot) || !upe_pkg::is_safe(data.path_byte);

    if (data.path_byte == upe_pkg::ChSlash) begin
      st_next.pend = 1'b1;
      if (data.is_last) begin
        if (st.phase == upe_pkg::PhaseNone) begin
          enc.item[0] = '{out_byte: upe_pkg::ChDash, byte_valid: 1'b1, end_of_name: 1'b0};
        end else begin
          enc.item[0] = '{out_byte: 8'd0, byte_valid: 1'b0, end_of_name: 1'b0};
        end
        n = upe_pkg::CntW'(1);
      end
    end else begin
      if (st.pend && st.phase != upe_pkg::PhaseNone) begin
        enc.item[0] = '{out_byte: upe_pkg::ChDash, byte_valid: 1'b1, end_of_name: 1'b0};
        n = upe_pkg::CntW'(1);
      end
      if (esc) begin
        enc.item[n[upe_pkg::IdxW-1:0]] =
          '{out_byte: upe_pkg::ChBsl, byte_valid: 1'b1, end_of_name: 1'b0};
        n = n + upe_pkg::CntW'(1);
        enc.item[n[upe_pkg::IdxW-1:0]] =
          '{out_byte: upe_pkg::ChX, byte_valid: 1'b1, end_of_name: 1'b0};
        n = n + upe_pkg::CntW'(1);
        enc.item[n[upe_pkg::IdxW-1:0]] =
          '{out_byte: upe_pkg::hex_char(data.path_byte[7:4]), byte_valid: 1'b1,
            end_of_name: 1'b0};
        n = n + upe_pkg::CntW'(1);
        enc.item[n[upe_pkg::IdxW-1:0]] =
          '{out_byte: upe_pkg::hex_char(data.path_byte[3:0]), byte_valid: 1'b1,
            end_of_name: 1'b0};
        n = n + upe_pkg::CntW'(1);
      end else begin
        enc.item[n[upe_pkg::IdxW-1:0]] =
          '{out_byte: data.path_byte, byte_valid: 1'b1, end_of_name: 1'b0};
        n = n + upe_pkg::CntW'(1);
      end
      st_next.pend  = 1'b0;
      st_next.phase = upe_pkg::PhaseKept;
    end

    if (data.is_last) begin
      if (n != '0) begin
        enc.item[n[upe_pkg::IdxW-1:0] - upe_pkg::IdxW'(1)].end_of_name = 1'b1;
      end
      st_next = '0;
    end
    enc.count = n;
  end

endmodule

// ===== rtl/unit_name_path_escaper_unit.sv =====
// The first result byte is offered in the cycle after the input transfer.
// One input byte is taken per cycle while each byte yields at most one result and the
//   result port is not stalled; a byte with more results stalls the input until only its last result remains.
// The limit is the single result port draining the result buffer one byte a cycle when not stalled.
// Reset (rst, synchronous, active high) empties the result buffer and clears the
//   slash and position state, so the next byte starts a new path.
`include "unit_name_path_escaper_unit_defines.svh"

module unit_name_path_escaper_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_stall,
  input  upe_pkg::in_t  up_data,
  output logic          dn_valid,
  input  logic          dn_stall,
  output upe_pkg::out_t dn_data
);

  upe_pkg::st_t                      st;
  upe_pkg::st_t                      st_next;
  upe_pkg::enc_t                     enc;
  upe_pkg::out_t [upe_pkg::MaxResults-1:0] rbuf;
  logic [upe_pkg::CntW-1:0]          count;
  logic                              up_xfer;
  logic                              dn_xfer;

  upe_encode u_encode (
    .data    (up_data),
    .st      (st),
    .enc     (enc),
    .st_next (st_next)
  );

  assign dn_valid = (count != '0);
  assign dn_data  = rbuf[0];
  assign dn_xfer  = dn_valid && !dn_stall;
  assign up_stall = !((count == '0) || (count == upe_pkg::CntW'(1) && !dn_stall));
  assign up_xfer  = up_valid && !up_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      count <= '0;
    end else if (up_xfer) begin
      st    <= st_next;
      rbuf  <= enc.item;
      count <= enc.count;
    end else if (dn_xfer) begin
      for (int i = 0; i < upe_pkg::MaxResults - 1; i++) begin
        rbuf[i] <= rbuf[i+1];
      end
      count <= count - upe_pkg::CntW'(1);
    end
  end

  `UPE_ASSERT_NOW(a_count_range, 1'b1, count <= upe_pkg::CntW'(upe_pkg::MaxResults), "result count out of range")
  `UPE_ASSERT_NOW(a_no_overrun, up_xfer, count == '0 || (count == upe_pkg::CntW'(1) && dn_xfer), "input taken over pending results")
  `UPE_ASSERT_NEXT(a_results_shown, up_xfer && enc.count != '0, dn_valid && count == $past(enc.count), "results not loaded")
  `UPE_ASSERT_NEXT(a_path_restart, up_xfer && up_data.is_last, st == '0, "state not cleared after last byte")

endmodule

// ===== tb/upe_name_checker.sv =====
module upe_name_checker
  import upe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  input  logic up_stall,
  input  in_t  up_data,
  input  logic dn_valid,
  input  logic dn_stall,
  input  out_t dn_data,
  output int   mismatches,
  output int   backlog
);

  logic       run_open;
  logic [1:0] name_phase;
  out_t       expected_name[$];
  out_t       want;

  initial begin
    mismatches = 0;
    backlog    = 0;
  end

  function automatic out_t name_byte(input logic [7:0] b, input logic data);
    return out_t'{out_byte: b, byte_valid: data, end_of_name: 1'b0};
  endfunction

  function automatic logic [7:0] nibble_text(input logic [3:0] n);
    if (n > 4'd9) begin
      return ChLowA + {4'd0, n} - 8'd10;
    end
    return ChZero + {4'd0, n};
  endfunction

  function automatic logic name_char_ok(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], ChColon, ChUnder, ChDot};
  endfunction

  task automatic expand_path_byte(input in_t t);
    out_t burst[$];
    out_t tail;
    logic head;
    if (t.path_byte == ChSlash) begin
      run_open = 1'b1;
      if (t.is_last) begin
        if (name_phase == PhaseNone) begin
          burst.push_back(name_byte(ChDash, 1'b1));
        end else begin
          burst.push_back(name_byte(8'h00, 1'b0));
        end
      end
    end else begin
      if (run_open) begin
        if (name_phase == PhaseNone) begin
          name_phase = PhaseSkipped;
        end else begin
          burst.push_back(name_byte(ChDash, 1'b1));
        end
        run_open = 1'b0;
      end
      head = !name_phase[1];
      if ((head && t.path_byte == ChDot) || !name_char_ok(t.path_byte)) begin
        burst.push_back(name_byte(ChBsl, 1'b1));
        burst.push_back(name_byte(ChX, 1'b1));
        burst.push_back(name_byte(nibble_text(t.path_byte[7:4]), 1'b1));
        burst.push_back(name_byte(nibble_text(t.path_byte[3:0]), 1'b1));
      end else begin
        burst.push_back(name_byte(t.path_byte, 1'b1));
      end
      name_phase = PhaseKept;
    end
    if (t.is_last) begin
      if (burst.size() > 0) begin
        tail = burst[burst.size() - 1];
        tail.end_of_name = 1'b1;
        burst[burst.size() - 1] = tail;
      end
      run_open   = 1'b0;
      name_phase = PhaseNone;
    end
    foreach (burst[i]) expected_name.push_back(burst[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      run_open   = 1'b0;
      name_phase = PhaseNone;
      expected_name.delete();
    end else begin
      if (dn_valid && !dn_stall) begin
        if (expected_name.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected name byte %h valid %b end %b", dn_data.out_byte,
                     dn_data.byte_valid, dn_data.end_of_name);
          end
          mismatches++;
        end else begin
          want = expected_name.pop_front();
          if (dn_data.out_byte !== want.out_byte || dn_data.byte_valid !== want.byte_valid ||
              dn_data.end_of_name !== want.end_of_name) begin
            if (mismatches < 10) begin
              $display("name byte mismatch: expected %h/%b/%b got %h/%b/%b",
                       want.out_byte, want.byte_valid, want.end_of_name,
                       dn_data.out_byte, dn_data.byte_valid, dn_data.end_of_name);
            end
            mismatches++;
          end
        end
      end
      if (up_valid && !up_stall) begin
        expand_path_byte(up_data);
      end
    end
    backlog = expected_name.size();
  end

endmodule

// ===== tb/tb_unit_name_path_escaper_unit.sv =====
module tb_unit_name_path_escaper_unit;
  import upe_pkg::*;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic up_valid = 1'b0;
  logic up_stall;
  in_t  up_data  = '0;
  logic dn_valid;
  logic dn_stall = 1'b0;
  out_t dn_data;

  int mismatches;
  int backlog;
  int items_sent = 0;
  int send_max   = 11;
  int recv_max   = 11;
  bit hold_req   = 1'b0;

  string      directed_paths[5] = '{"/", "//", ".a/", "/./b", "z//.:"};
  logic [7:0] odd_bytes[8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h2D, 8'h5F, 8'h40, 8'h7B};

  unit_name_path_escaper_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .up_valid (up_valid),
    .up_stall (up_stall),
    .up_data  (up_data),
    .dn_valid (dn_valid),
    .dn_stall (dn_stall),
    .dn_data  (dn_data)
  );

  upe_name_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (up_valid),
    .up_stall   (up_stall),
    .up_data    (up_data),
    .dn_valid   (dn_valid),
    .dn_stall   (dn_stall),
    .dn_data    (dn_data),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  always #10 clk = ~clk;

  initial begin
    #8000000;
    $display("unit_name_path_escaper_unit regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, send_max);
    repeat (gap) @(negedge clk) up_valid <= 1'b0;
    @(negedge clk);
    up_valid <= 1'b1;
    up_data  <= in_t'{path_byte: b, is_last: last};
    do @(posedge clk); while (up_stall);
    items_sent++;
  endtask

  task automatic drain_names();
    @(negedge clk);
    up_valid <= 1'b0;
    wait (backlog == 0);
  endtask

  function automatic logic [7:0] random_path_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return ChSlash;
    if (pick < 25) return ChDot;
    if (pick < 40) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: return 8'h30 + 8'($urandom_range(0, 9));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      2: return 8'h61 + 8'($urandom_range(0, 25));
      3: return ChColon;
      default: return ChUnder;
    endcase
  endfunction

  task automatic send_random_path();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      send_byte(random_path_byte(), i == len - 1);
    end
  endtask

  initial begin
    int w;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (80) @(negedge clk) dn_stall <= 1'b1;
      end
      w = $urandom_range(0, recv_max);
      repeat (w) @(negedge clk) dn_stall <= 1'b1;
      @(negedge clk);
      dn_stall <= 1'b0;
      do @(posedge clk); while (!dn_valid);
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_paths[p]) begin
      for (int i = 0; i < directed_paths[p].len(); i++) begin
        send_byte(directed_paths[p][i], i == directed_paths[p].len() - 1);
      end
    end
    foreach (odd_bytes[i]) send_byte(odd_bytes[i], i == 7);

    while (items_sent < 150) send_random_path();

    send_max = 0;
    hold_req = 1'b1;
    repeat (4) send_random_path();
    send_max = 11;
    drain_names();

    send_max = 0;
    recv_max = 0;
    while (items_sent < 250) send_random_path();
    send_max = 11;
    recv_max = 11;

    while (items_sent < 370) send_random_path();

    drain_names();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("unit_name_path_escaper_unit regression: pass");
    end else begin
      $display("unit_name_path_escaper_unit regression: fail");
    end
    $finish;
  end

endmodule
